>>> rtl/aicr_pkg.sv
// Package for the access interval cache replacement unit.
// Holds command codes, sequencer states, hash function and default sizes.
// No dependencies.
package aicr_pkg;

  localparam int unsigned DefWays       = 8;
  localparam int unsigned DefSets       = 64;
  localparam int unsigned DefCounterMax = 15;
  localparam int unsigned HashW         = 8;
  localparam int unsigned PtDepth       = 65536;
  localparam int unsigned PtAw          = 16;
  localparam int unsigned CmdW          = 3;
  localparam int unsigned SetW          = 6;
  localparam int unsigned WayInW        = 3;
  localparam int unsigned AddrW         = 48;
  localparam int unsigned TickW         = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_ACCESS = 3'd0,
    CMD_HIT    = 3'd1,
    CMD_FILL   = 3'd2,
    CMD_QUERY  = 3'd3,
    CMD_EVICT  = 3'd4,
    CMD_INVAL  = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_RDWAIT,
    ST_EXEC,
    ST_PTWAIT,
    ST_PTDONE,
    ST_WRITE,
    ST_SCAN,
    ST_SCANWAIT,
    ST_SCANSTEP,
    ST_RESULT
  } state_t;

  function automatic logic [HashW-1:0] fold8(input logic [AddrW-1:0] v);
    logic [HashW-1:0] h;
    h = '0;
    for (int i = 0; i < AddrW / HashW; i++) begin
      h = h ^ v[i*HashW +: HashW];
    end
    return h;
  endfunction

endpackage

>>> rtl/aicr_way_mem.sv
// Way record memory: one entry per set and way, one read and one write port.
// Does not use aicr_pkg; pure storage.
// Read data is registered.
module aicr_way_mem #(
  parameter int unsigned Depth = 512,
  parameter int unsigned Aw    = 9,
  parameter int unsigned Dw    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [Aw-1:0] waddr,
  input  logic [Dw-1:0] wdata,
  input  logic [Aw-1:0] raddr,
  output logic [Dw-1:0] rdata
);

  logic [Dw-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/access_interval_cache_replacement_unit.sv
// Top level of the access interval cache replacement unit.
// Uses aicr_pkg and aicr_way_mem (way records and prediction table).
// Sequencer walks the ways of a set through one shared compare/update path.
//
//   channel | direction | handshake          | payload
//   in      | request   | in_valid/in_stall  | cmd set_index way pc pc_valid line_addr now_tick
//   out     | result    | out_valid/out_stall| victim_way found_expired
//
// After reset a clearing pass zeroes the prediction table and the way records;
// no request is taken meanwhile.
// Hit, fill, eviction, invalidate: read, read wait, execute, table wait, done.
// Set access: per way a read, read wait and write, one read-modify-write a way.
// Victim query: two passes of read, read wait and step per way until the result
// is offered. Unused codes and out-of-range ways return to idle after the read
// state. Results wait in an output register while out_stall is high; the next
// request is accepted once the result has left.
module access_interval_cache_replacement_unit
  import aicr_pkg::*;
#(
  parameter int unsigned WAYS        = DefWays,
  parameter int unsigned SETS        = DefSets,
  parameter int unsigned COUNTER_MAX = DefCounterMax
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [aicr_pkg::CmdW-1:0] cmd,
  input  logic [aicr_pkg::SetW-1:0] set_index,
  input  logic [aicr_pkg::WayInW-1:0] way,
  input  logic [aicr_pkg::AddrW-1:0] pc,
  input  logic                      pc_valid,
  input  logic [aicr_pkg::AddrW-1:0] line_addr,
  input  logic [aicr_pkg::TickW-1:0] now_tick,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                victim_way,
  output logic                      found_expired
);

  localparam int unsigned WayW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned SetIw = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned Aw    = SetIw + WayW;
  localparam int unsigned Depth = SETS * (2 ** WayW);
  localparam int unsigned CntW  = $clog2(COUNTER_MAX + 1);
  localparam int unsigned RecW  = HashW + 3 * CntW + 1 + TickW;
  localparam int unsigned ClrW  = PtAw + 1;

  typedef struct packed {
    logic [HashW-1:0] hash;
    logic [CntW-1:0]  cnt;
    logic [CntW-1:0]  past;
    logic [CntW-1:0]  pres;
    logic             conf;
    logic [TickW-1:0] tick;
  } rec_t;

  state_t state, state_next;

  logic [CmdW-1:0]   r_cmd;
  logic [SetW-1:0]   r_set;
  logic [WayInW-1:0] r_way;
  logic [HashW-1:0]  r_hpc;
  logic [HashW-1:0]  r_hadr;
  logic [TickW-1:0]  r_tick;
  logic [ClrW-1:0]   clr;
  logic [WayW:0]     scan;
  logic              pass2;
  logic [TickW-1:0]  mru;
  logic [TickW-1:0]  best_tick;
  logic [TickW-1:0]  lru_tick;
  logic [WayW-1:0]   best;
  logic [WayW-1:0]   lru;
  logic              have_best;
  logic [2:0]        res_way;
  logic              res_exp;
  logic              ovalid;

  logic              wm_we;
  logic [Aw-1:0]     wm_waddr;
  logic [Aw-1:0]     wm_raddr;
  rec_t              wm_wdata;
  rec_t              wm_rdata;
  logic [RecW-1:0]   wm_rbits;

  logic              pt_we;
  logic [PtAw-1:0]   pt_waddr;
  logic [PtAw-1:0]   pt_raddr;
  logic [CntW:0]     pt_wdata;
  logic [CntW:0]     pt_rdata;

  logic [WayW-1:0]   way_lo;
  logic [WayW-1:0]   scan_lo;
  logic [SetIw-1:0]  set_lo;
  logic              set_ok;
  logic              way_ok;
  logic              accept;
  logic [CntW-1:0]   done_cnt;
  logic              expired;

  assign wm_rdata = rec_t'(wm_rbits);

  aicr_way_mem #(.Depth(Depth), .Aw(Aw), .Dw(RecW)) u_way (
    .clk(clk), .we(wm_we), .waddr(wm_waddr), .wdata(wm_wdata),
    .raddr(wm_raddr), .rdata(wm_rbits)
  );

  aicr_way_mem #(.Depth(PtDepth), .Aw(PtAw), .Dw(CntW + 1)) u_pt (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  assign way_lo  = WayW'(r_way);
  assign scan_lo = scan[WayW-1:0];
  assign set_lo  = SetIw'(r_set);
  assign set_ok  = 32'(r_set) < SETS;
  assign way_ok  = 32'(r_way) < WAYS;
  assign accept  = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE) || ovalid;
  assign out_valid = ovalid;
  assign victim_way = res_way;
  assign found_expired = res_exp;

  assign done_cnt = (wm_rdata.cnt != '0) ? wm_rdata.cnt - CntW'(1) : '0;
  assign expired = (wm_rdata.tick != mru) && wm_rdata.conf &&
                   (wm_rdata.cnt > wm_rdata.past) && (wm_rdata.cnt > wm_rdata.pres);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr <= clr + ClrW'(1);
      end
      if (ovalid && !out_stall) begin
        ovalid <= 1'b0;
      end
      if (state == ST_RESULT) begin
        ovalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_cmd  <= cmd;
      r_set  <= set_index;
      r_way  <= way;
      r_hpc  <= pc_valid ? fold8(pc) : '0;
      r_hadr <= fold8(line_addr);
      r_tick <= now_tick;
      scan   <= '0;
      pass2  <= 1'b0;
      mru    <= '0;
      have_best <= 1'b0;
      best   <= '0;
      lru    <= '0;
      res_way <= '0;
      res_exp <= 1'b0;
    end
    if (state == ST_WRITE) begin
      scan <= scan + (WayW + 1)'(1);
    end
    if (state == ST_SCANSTEP) begin
      if (!pass2) begin
        if (wm_rdata.tick > mru) begin
          mru <= wm_rdata.tick;
        end
      end else begin
        if (expired && (!have_best || wm_rdata.tick < best_tick)) begin
          have_best <= 1'b1;
          best <= scan_lo;
          best_tick <= wm_rdata.tick;
        end
        if (scan == '0 || wm_rdata.tick < lru_tick) begin
          lru <= scan_lo;
          lru_tick <= wm_rdata.tick;
        end
      end
      if (32'(scan) == WAYS - 1) begin
        scan  <= '0;
        pass2 <= 1'b1;
      end else begin
        scan <= scan + (WayW + 1)'(1);
      end
    end
    if (state == ST_SCANSTEP && pass2 && 32'(scan) == WAYS - 1) begin
      res_exp <= have_best || (expired && (!have_best || wm_rdata.tick < best_tick));
      if (expired && (!have_best || wm_rdata.tick < best_tick)) begin
        res_way <= 3'(scan_lo);
      end else if (have_best) begin
        res_way <= 3'(best);
      end else if (wm_rdata.tick < lru_tick) begin
        res_way <= 3'(scan_lo);
      end else begin
        res_way <= 3'(lru);
      end
    end
  end

  always_comb begin
    state_next = state;
    wm_we    = 1'b0;
    wm_waddr = {set_lo, way_lo};
    wm_raddr = {set_lo, way_lo};
    wm_wdata = wm_rdata;
    pt_we    = 1'b0;
    pt_waddr = {wm_rdata.hash, r_hadr};
    pt_raddr = {r_hpc, r_hadr};
    pt_wdata = {(wm_rdata.pres == pt_rdata[CntW-1:0]), wm_rdata.pres};
    unique case (state)
      ST_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clr[PtAw-1:0];
        pt_wdata = '0;
        wm_we    = 32'(clr) < Depth;
        wm_waddr = Aw'(clr);
        wm_wdata = '0;
        if (clr[PtAw]) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (r_cmd > CMD_INVAL) begin
          state_next = ST_IDLE;
        end else if (!set_ok) begin
          state_next = (r_cmd == CMD_QUERY) ? ST_RESULT : ST_IDLE;
        end else if (r_cmd == CMD_ACCESS || r_cmd == CMD_QUERY) begin
          state_next = ST_SCAN;
        end else if (!way_ok) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_RDWAIT;
        end
      end
      ST_RDWAIT: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_PTWAIT;
      end
      ST_PTWAIT: begin
        state_next = ST_PTDONE;
      end
      ST_PTDONE: begin
        state_next = ST_IDLE;
        case (r_cmd)
          CMD_HIT: begin
            wm_we = 1'b1;
            if (done_cnt > wm_rdata.pres) begin
              wm_wdata.pres = done_cnt;
            end
            wm_wdata.cnt  = '0;
            wm_wdata.tick = r_tick;
          end
          CMD_FILL: begin
            wm_we = 1'b1;
            wm_wdata.cnt  = '0;
            wm_wdata.pres = '0;
            wm_wdata.tick = r_tick;
            wm_wdata.hash = r_hpc;
            wm_wdata.past = pt_rdata[CntW-1:0];
            wm_wdata.conf = pt_rdata[CntW];
          end
          CMD_EVICT: begin
            pt_we = 1'b1;
          end
          default: begin
            wm_we = 1'b1;
            wm_wdata = '0;
          end
        endcase
      end
      ST_WRITE: begin
        wm_we    = 1'b1;
        wm_waddr = {set_lo, scan_lo};
        if (wm_rdata.cnt < CntW'(COUNTER_MAX)) begin
          wm_wdata.cnt = wm_rdata.cnt + CntW'(1);
        end
        state_next = (32'(scan) == WAYS - 1) ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        wm_raddr = {set_lo, scan_lo};
        state_next = ST_SCANWAIT;
      end
      ST_SCANWAIT: begin
        wm_raddr = {set_lo, scan_lo};
        state_next = (r_cmd == CMD_ACCESS) ? ST_WRITE : ST_SCANSTEP;
      end
      ST_SCANSTEP: begin
        if (pass2 && 32'(scan) == WAYS - 1) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_RESULT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (state == ST_PTWAIT || state == ST_PTDONE) begin
      pt_raddr = (r_cmd == CMD_EVICT) ? {wm_rdata.hash, r_hadr} : {r_hpc, r_hadr};
    end
  end

endmodule

>>> test/testbench.sv
// Testbench for access_interval_cache_replacement_unit.
// Predicts victim choices from its own copy of the way records and prediction table,
// drives random and directed cache events; depends on aicr_pkg and the unit.
`timescale 1ns / 100ps

module testbench;
  import aicr_pkg::*;

  localparam int NWAYS = 8;
  localparam int NSETS = 64;
  localparam int CMAX = 15;
  localparam int IDLE_LIMIT = 200000;

  typedef struct packed {
    logic [2:0] victim;
    logic       expired;
  } victim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CmdW-1:0] cmd = '0;
  logic [SetW-1:0] set_index = '0;
  logic [WayInW-1:0] way = '0;
  logic [AddrW-1:0] pc = '0;
  logic pc_valid = 1'b0;
  logic [AddrW-1:0] line_addr = '0;
  logic [TickW-1:0] now_tick = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] victim_way;
  logic found_expired;

  logic [7:0]  rec_hash [NSETS*NWAYS];
  logic [3:0]  rec_count [NSETS*NWAYS];
  logic [3:0]  rec_past [NSETS*NWAYS];
  logic [3:0]  rec_pres [NSETS*NWAYS];
  logic        rec_conf [NSETS*NWAYS];
  logic [31:0] rec_tick [NSETS*NWAYS];
  logic [3:0]  pt_past [65536];
  logic        pt_conf [65536];

  victim_t victim_queue[$];
  int errors = 0;
  int idle_cycles = 0;
  int out_wait = 0;
  logic [31:0] tick_ctr = 32'd1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  access_interval_cache_replacement_unit DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .set_index(set_index), .way(way), .pc(pc), .pc_valid(pc_valid),
    .line_addr(line_addr), .now_tick(now_tick), .out_valid(out_valid),
    .out_stall(out_stall), .victim_way(victim_way), .found_expired(found_expired)
  );

  function automatic logic [7:0] xor_bytes(logic [47:0] v);
    logic [7:0] h;
    h = '0;
    for (int i = 0; i < 6; i++) h ^= v[i*8 +: 8];
    return h;
  endfunction

  task automatic predict_event(logic [2:0] c, logic [5:0] s, logic [2:0] w, logic [47:0] p,
                               logic pv, logic [47:0] a, logic [31:0] t);
    int base;
    int e;
    int ti;
    logic [31:0] mru;
    logic [31:0] best_t;
    int best;
    int lru;
    logic [3:0] done;
    logic [7:0] hp;
    logic exp_w;
    victim_t r;
    base = s * NWAYS;
    e = base + w;
    case (c)
      CMD_ACCESS: begin
        for (int i = 0; i < NWAYS; i++)
          if (rec_count[base+i] < CMAX) rec_count[base+i]++;
      end
      CMD_QUERY: begin
        mru = '0;
        best = -1;
        best_t = '0;
        lru = 0;
        for (int i = 0; i < NWAYS; i++) if (rec_tick[base+i] > mru) mru = rec_tick[base+i];
        for (int i = 0; i < NWAYS; i++) begin
          exp_w = rec_tick[base+i] != mru && rec_conf[base+i] &&
                  rec_count[base+i] > rec_past[base+i] && rec_count[base+i] > rec_pres[base+i];
          if (exp_w && (best < 0 || rec_tick[base+i] < best_t)) begin
            best = i;
            best_t = rec_tick[base+i];
          end
          if (rec_tick[base+i] < rec_tick[base+lru]) lru = i;
        end
        r.victim = (best >= 0) ? best[2:0] : lru[2:0];
        r.expired = best >= 0;
        victim_queue.push_back(r);
      end
      CMD_HIT: begin
        done = rec_count[e];
        if (done > 0) done--;
        if (done > rec_pres[e]) rec_pres[e] = done;
        rec_count[e] = '0;
        rec_tick[e] = t;
      end
      CMD_FILL: begin
        hp = pv ? xor_bytes(p) : 8'd0;
        ti = int'({hp, xor_bytes(a)});
        rec_count[e] = '0;
        rec_pres[e] = '0;
        rec_tick[e] = t;
        rec_hash[e] = hp;
        rec_past[e] = pt_past[ti];
        rec_conf[e] = pt_conf[ti];
      end
      CMD_EVICT: begin
        ti = int'({rec_hash[e], xor_bytes(a)});
        pt_conf[ti] = rec_pres[e] == pt_past[ti];
        pt_past[ti] = rec_pres[e];
      end
      CMD_INVAL: begin
        rec_hash[e] = '0; rec_count[e] = '0; rec_past[e] = '0;
        rec_pres[e] = '0; rec_conf[e] = 1'b0; rec_tick[e] = '0;
      end
      default: ;
    endcase
  endtask

  task automatic send_request(logic [2:0] c, logic [5:0] s, logic [2:0] w, logic [47:0] p,
                              logic pv, logic [47:0] a, logic [31:0] t);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c; set_index <= s; way <= w; pc <= p; pc_valid <= pv;
    line_addr <= a; now_tick <= t; in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_event(c, s, w, p, pv, a, t);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic send_random(logic [2:0] c, logic [5:0] s);
    tick_ctr = tick_ctr + $urandom_range(1, 3);
    send_request(c, s, 3'($urandom_range(0, 7)), rand48(), 1'($urandom_range(0, 1)),
                 {40'd0, 8'($urandom_range(0, 3))}, tick_ctr);
  endtask

  task automatic test_directed();
    send_request(CMD_QUERY, 6'd0, 3'd0, '0, 1'b0, '0, '0);
    send_request(CMD_FILL, 6'd63, 3'd7, '1, 1'b1, '1, '1);
    send_request(CMD_FILL, 6'd63, 3'd0, '1, 1'b0, '0, 32'd5);
    for (int i = 0; i < 16; i++) send_request(CMD_ACCESS, 6'd63, 3'd0, '0, 1'b0, '0, '0);
    send_request(CMD_HIT, 6'd63, 3'd0, '0, 1'b0, '0, 32'd6);
    send_request(CMD_EVICT, 6'd63, 3'd7, '0, 1'b0, '1, '0);
    send_request(CMD_QUERY, 6'd63, 3'd0, '0, 1'b0, '0, '0);
    send_request(3'd6, 6'd63, 3'd0, '0, 1'b0, '0, '0);
    send_request(3'd7, 6'd0, 3'd7, '1, 1'b1, '1, '1);
    send_request(CMD_INVAL, 6'd63, 3'd7, '0, 1'b0, '0, '0);
    send_request(CMD_QUERY, 6'd63, 3'd0, '0, 1'b0, '0, '0);
  endtask

  // fill, reuse at a steady interval, evict and refill so the table gains confidence
  task automatic test_random();
    logic [5:0] s;
    int n;
    int per;
    n = 0;
    while (n < 640) begin
      s = 6'($urandom_range(0, 3));
      if ($urandom_range(0, 4) == 0) begin
        send_random(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)));
        n++;
      end else begin
        per = $urandom_range(0, 3);
        send_random(CMD_FILL, s);
        for (int k = 0; k < 3; k++) begin
          for (int j = 0; j < per; j++) send_random(CMD_ACCESS, s);
          send_random($urandom_range(0, 1) ? CMD_HIT : CMD_QUERY, s);
        end
        for (int j = 0; j < 6; j++) send_random(CMD_ACCESS, s);
        send_random(CMD_QUERY, s);
        send_random(CMD_EVICT, s);
        n += 3 * per + 12;
      end
    end
  endtask

  always @(posedge clk) begin : out_side
    int draw;
    if (rst) begin
      draw = $urandom_range(0, 8);
      out_wait <= draw;
      out_stall <= (draw != 0);
    end else if (out_valid && !out_stall) begin
      if (victim_queue.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %0d/%0d", $time,
                 victim_way, found_expired);
        errors++;
      end else begin
        if (victim_way !== victim_queue[0].victim) begin
          $display("%0t victim_way mismatch: expected %0d, actual %0d", $time,
                   victim_queue[0].victim, victim_way);
          errors++;
        end
        if (found_expired !== victim_queue[0].expired) begin
          $display("%0t found_expired mismatch: expected %0d, actual %0d", $time,
                   victim_queue[0].expired, found_expired);
          errors++;
        end
        void'(victim_queue.pop_front());
      end
      draw = $urandom_range(0, 8);
      out_wait <= draw;
      out_stall <= (draw != 0);
    end else if (out_valid && out_wait > 0) begin
      out_wait <= out_wait - 1;
      out_stall <= (out_wait > 1);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NSETS*NWAYS; i++) begin
      rec_hash[i] = '0; rec_count[i] = '0; rec_past[i] = '0;
      rec_pres[i] = '0; rec_conf[i] = 1'b0; rec_tick[i] = '0;
    end
    for (int i = 0; i < 65536; i++) begin
      pt_past[i] = '0;
      pt_conf[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    in_valid <= 1'b0;
    while (victim_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
